[sv/cdid_pkg.sv]
package cdid_pkg;

    // field and state widths
    localparam int unsigned MIN_W   = 7;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned TIME_W  = 13;
    localparam int unsigned TOTAL_W = 12;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned SPAN_W  = 16;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [TIME_W-1:0] SEC_PER_MIN = TIME_W'(60);

    // divide by ten: floor(v * 52429 / 2^19) is exact for every 13 bit v
    localparam int unsigned       DIV10_MUL_W = 16;
    localparam int unsigned       DIV10_SHIFT = 19;
    localparam int unsigned       DIV10_PROD_W = TIME_W + DIV10_MUL_W;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(52429);
    localparam logic [TIME_W-1:0] TEN = TIME_W'(10);

    // modulo 255 of the digit total
    localparam logic [8:0] MOD_BASE = 9'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_DIGIT,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic digit;
        logic commit;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic leadout;
        logic full;
        logic val_zero;
    } t_dp_status;

endpackage

[sv/cdid_ctrl.sv]
module cdid_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cdid_pkg::t_dp_status i_status,
    output cdid_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);

    cdid_pkg::t_state r_state;
    cdid_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdid_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdid_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = cdid_pkg::ST_TIME;
                end
            end
            cdid_pkg::ST_TIME: begin
                priority if (i_status.leadout) begin
                    n_state = cdid_pkg::ST_EMIT;
                end else if (i_status.full) begin
                    n_state = cdid_pkg::ST_IDLE;
                end else begin
                    n_state = cdid_pkg::ST_DIGIT;
                end
            end
            cdid_pkg::ST_DIGIT: begin
                if (i_status.val_zero) begin
                    n_state = cdid_pkg::ST_COMMIT;
                end
            end
            cdid_pkg::ST_COMMIT: n_state = cdid_pkg::ST_IDLE;
            cdid_pkg::ST_EMIT:   n_state = cdid_pkg::ST_IDLE;
            default:             n_state = cdid_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            cdid_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            cdid_pkg::ST_TIME:   o_cmd.calc   = 1'b1;
            cdid_pkg::ST_DIGIT:  o_cmd.digit  = !i_status.val_zero;
            cdid_pkg::ST_COMMIT: o_cmd.commit = 1'b1;
            cdid_pkg::ST_EMIT:   o_cmd.emit   = 1'b1;
            default:             o_cmd        = '0;
        endcase
    end

endmodule

[sv/cdid_dp.sv]
module cdid_dp #(
    parameter int unsigned MAX_TRACKS = 99
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cdid_pkg::MIN_W-1:0]          i_minutes,
    input  logic [cdid_pkg::SEC_W-1:0]          i_seconds,
    input  logic                                i_is_leadout,
    input  cdid_pkg::t_dp_cmd                   i_cmd,
    output cdid_pkg::t_dp_status                o_status,
    output logic [cdid_pkg::ID_W-1:0]           o_disc_id,
    output logic                                o_valid
);

    localparam logic [cdid_pkg::COUNT_W-1:0] MAX_COUNT = cdid_pkg::COUNT_W'(MAX_TRACKS);

    // latched entry
    logic [cdid_pkg::MIN_W-1:0]   r_minutes;
    logic [cdid_pkg::SEC_W-1:0]   r_seconds;
    logic                         r_leadout;
    logic [cdid_pkg::TIME_W-1:0]  r_time;
    logic [cdid_pkg::TIME_W-1:0]  r_val;

    // disc state
    logic [cdid_pkg::TOTAL_W-1:0] r_digit_total;
    logic [cdid_pkg::TIME_W-1:0]  r_first_time;
    logic [cdid_pkg::COUNT_W-1:0] r_track_count;
    logic                         r_first_seen;

    logic [cdid_pkg::ID_W-1:0]    r_disc_id;
    logic                         r_valid;

    logic [cdid_pkg::TIME_W-1:0]       entry_time;
    logic [cdid_pkg::DIV10_PROD_W-1:0] div_prod;
    logic [cdid_pkg::TIME_W-1:0]       quot;
    logic [cdid_pkg::TIME_W-1:0]       quot_x10;
    logic [cdid_pkg::DIGIT_W-1:0]      digit;
    logic [8:0]                        fold;
    logic [7:0]                        total_mod;
    logic [cdid_pkg::TIME_W-1:0]       base_time;
    logic [cdid_pkg::SPAN_W-1:0]       span;

    assign entry_time = cdid_pkg::TIME_W'(r_minutes) * cdid_pkg::SEC_PER_MIN
                      + cdid_pkg::TIME_W'(r_seconds);

    // one decimal digit per step
    assign div_prod = cdid_pkg::DIV10_PROD_W'(r_val)
                    * cdid_pkg::DIV10_PROD_W'(cdid_pkg::DIV10_MUL);
    assign quot     = cdid_pkg::TIME_W'(div_prod >> cdid_pkg::DIV10_SHIFT);
    assign quot_x10 = cdid_pkg::TIME_W'(quot * cdid_pkg::TEN);
    assign digit    = cdid_pkg::DIGIT_W'(r_val - quot_x10);

    // 256 = 1 mod 255, so fold the high nibble onto the low byte
    assign fold      = 9'(r_digit_total[7:0]) + 9'(r_digit_total[11:8]);
    assign total_mod = (fold >= cdid_pkg::MOD_BASE) ? 8'(fold - cdid_pkg::MOD_BASE)
                                                    : fold[7:0];
    assign base_time = r_first_seen ? r_first_time : r_time;
    assign span      = cdid_pkg::SPAN_W'(r_time) - cdid_pkg::SPAN_W'(base_time);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_minutes <= i_minutes;
            r_seconds <= i_seconds;
        end
        if (i_cmd.calc) begin
            r_time <= entry_time;
        end
        if (i_cmd.calc) begin
            r_val <= entry_time;
        end else if (i_cmd.digit) begin
            r_val <= quot;
        end
        if (i_cmd.emit) begin
            r_disc_id <= {total_mod, span, 1'b0, r_track_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leadout     <= 1'b0;
            r_digit_total <= '0;
            r_first_time  <= '0;
            r_track_count <= '0;
            r_first_seen  <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_leadout <= i_is_leadout;
            end
            if (i_cmd.digit) begin
                r_digit_total <= r_digit_total + cdid_pkg::TOTAL_W'(digit);
            end
            if (i_cmd.commit) begin
                r_track_count <= r_track_count + cdid_pkg::COUNT_W'(1);
                if (!r_first_seen) begin
                    r_first_time <= r_time;
                    r_first_seen <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_digit_total <= '0;
                r_first_time  <= '0;
                r_track_count <= '0;
                r_first_seen  <= 1'b0;
            end
        end
    end

    assign o_status.leadout  = r_leadout;
    assign o_status.full     = (r_track_count >= MAX_COUNT);
    assign o_status.val_zero = (r_val == '0);
    assign o_disc_id         = r_disc_id;
    assign o_valid           = r_valid;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_track_count <= MAX_COUNT)
        else $error("track count beyond limit");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_track_count == '0) && !r_first_seen && (r_digit_total == '0))
        else $error("disc state not cleared after id");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.emit))
        else $error("strobe without lead-out");

    a_digit_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.digit |=> (r_val < $past(r_val)))
        else $error("digit step did not reduce value");
`endif

endmodule

[sv/cd_disc_id_hash_top.sv]
// disc id engine: feed the table of contents one entry per word (start address in
// minutes and seconds, lead-out flag on the last entry). a word is taken when start
// is high and busy is low. a track word is taken, minutes*60+seconds is formed, the
// digit loop sums the decimal digits of that time until the value reaches zero, and
// then the count is updated; the loop runs through a single divide-by-ten unit. a
// lead-out word is taken, its time is formed, and the 32 bit id then appears on
// o_disc_id with o_valid high for exactly one cycle, after which the disc state is
// clear for the next disc. the id cannot be held off: capture it on the strobe.
// track words past MAX_TRACKS are dropped without effect.
module cd_disc_id_hash_top #(
    parameter int unsigned MAX_TRACKS = 99
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cdid_pkg::MIN_W-1:0]  i_minutes,
    input  logic [cdid_pkg::SEC_W-1:0]  i_seconds,
    input  logic                        i_is_leadout,
    output logic [cdid_pkg::ID_W-1:0]   o_disc_id,
    output logic                        o_valid
);

    // command and status between sequencer and datapath
    cdid_pkg::t_dp_cmd    cmd;
    cdid_pkg::t_dp_status status;

    // sequencer: idle, time, digit loop, commit or emit
    cdid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath: entry latch, digit sum, disc state and id register
    cdid_dp #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_minutes    (i_minutes),
        .i_seconds    (i_seconds),
        .i_is_leadout (i_is_leadout),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_disc_id    (o_disc_id),
        .o_valid      (o_valid)
    );

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_TRACKS    = 99;
    localparam int unsigned N_WORDS       = 1700;  // rough size of the random part
    localparam int unsigned CALM_TAIL     = 150;   // last words go in with no idling
    localparam int unsigned SETTLE_CYCLES = 16;    // idle wait after the last expected id
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned LAST_SEC      = 127 * 60 + 59;

    // expected disc ids, worked out from the words that the block took
    class disc_id_board;
        logic [cdid_pkg::TOTAL_W-1:0] digit_total;
        logic [cdid_pkg::TIME_W-1:0]  first_time;
        logic [cdid_pkg::COUNT_W-1:0] track_count;
        logic                         first_seen;
        logic [cdid_pkg::ID_W-1:0]    pending_ids[$];
        int unsigned                  n_errors;

        function new();
            n_errors = 0;
            clear_disc();
        endfunction

        function void clear_disc();
            digit_total = '0;
            first_time  = '0;
            track_count = '0;
            first_seen  = 1'b0;
        endfunction

        function logic [cdid_pkg::TOTAL_W-1:0] digit_sum(logic [cdid_pkg::TIME_W-1:0] v);
            logic [cdid_pkg::TIME_W-1:0]  rest;
            logic [cdid_pkg::TOTAL_W-1:0] acc;
            rest = v;
            acc  = '0;
            while (rest != 0) begin
                acc  = acc + cdid_pkg::TOTAL_W'(rest % 10);
                rest = rest / 10;
            end
            return acc;
        endfunction

        function void note_word(logic [cdid_pkg::MIN_W-1:0] m, logic [cdid_pkg::SEC_W-1:0] s,
                                logic leadout);
            logic [cdid_pkg::TIME_W-1:0] t;
            logic [cdid_pkg::SPAN_W-1:0] span;
            t = cdid_pkg::TIME_W'(m) * cdid_pkg::SEC_PER_MIN + cdid_pkg::TIME_W'(s);
            if (!leadout) begin
                // tracks past the limit leave no trace at all
                if (track_count >= MAX_TRACKS)
                    return;
                if (!first_seen) begin
                    first_time = t;
                    first_seen = 1'b1;
                end
                digit_total = digit_total + digit_sum(t);
                track_count = track_count + cdid_pkg::COUNT_W'(1);
            end else begin
                // an empty disc takes its own lead-out as the first entry
                if (!first_seen)
                    first_time = t;
                span = cdid_pkg::SPAN_W'(t) - cdid_pkg::SPAN_W'(first_time);
                pending_ids.push_back({8'(digit_total % 255), span, 8'(track_count)});
                clear_disc();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            n_errors++;
        endtask

        task check_id(logic [cdid_pkg::ID_W-1:0] id);
            logic [cdid_pkg::ID_W-1:0] want;
            if (pending_ids.size() == 0) begin
                report($sformatf("disc id %h with none expected", id));
            end else begin
                want = pending_ids.pop_front();
                if (id !== want)
                    report($sformatf("disc id %h (sum %h span %h count %h), expected %h",
                                     id, id[31:24], id[23:8], id[7:0], want));
            end
        endtask
    endclass

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         start        = 1'b0;
    logic [cdid_pkg::MIN_W-1:0]   i_minutes    = '0;
    logic [cdid_pkg::SEC_W-1:0]   i_seconds    = '0;
    logic                         i_is_leadout = 1'b0;
    logic                         busy;
    logic [cdid_pkg::ID_W-1:0]    o_disc_id;
    logic                         o_valid;

    disc_id_board board = new();

    int unsigned n_sent       = 0;
    int unsigned stretch_left = 0;
    bit          idle_on      = 1'b0;
    int unsigned cycle_count  = 0;

    cd_disc_id_hash_top #(
        .MAX_TRACKS   (MAX_TRACKS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_minutes    (i_minutes),
        .i_seconds    (i_seconds),
        .i_is_leadout (i_is_leadout),
        .o_disc_id    (o_disc_id),
        .o_valid      (o_valid)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost id ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // monitor: values seen here are the ones from before the edge, so a word
    // counts as taken when start was high and busy low, and the id is
    // captured on its one-cycle strobe
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            board.note_word(i_minutes, i_seconds, i_is_leadout);
        if (i_rst_n && o_valid)
            board.check_id(o_disc_id);
    end

    // hold a word on the inputs until the block takes it
    task automatic send_word(input logic [cdid_pkg::MIN_W-1:0] m,
                             input logic [cdid_pkg::SEC_W-1:0] s,
                             input logic leadout);
        start        <= 1'b1;
        i_minutes    <= m;
        i_seconds    <= s;
        i_is_leadout <= leadout;
        do
            @(posedge i_clk);
        while (busy);
        n_sent++;
    endtask

    // sender side idling: stretches with idle gaps before some words
    // alternate with stretches of back-to-back words, none in the tail
    task automatic put_word(input logic [cdid_pkg::MIN_W-1:0] m,
                            input logic [cdid_pkg::SEC_W-1:0] s,
                            input logic leadout);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(10, 60);
            idle_on      = ($urandom_range(0, 2) != 0);
        end
        stretch_left--;
        if (idle_on && n_sent + CALM_TAIL < N_WORDS && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        send_word(m, s, leadout);
    endtask

    // one entry at a time in seconds; now and then a wild word instead,
    // which covers out of range fields and entries out of order
    task automatic put_time(input int unsigned t, input logic leadout);
        if ($urandom_range(0, 7) == 0)
            put_word(cdid_pkg::MIN_W'($urandom_range(0, 127)),
                     cdid_pkg::SEC_W'($urandom_range(0, 63)), leadout);
        else
            put_word(cdid_pkg::MIN_W'(t / 60), cdid_pkg::SEC_W'(t % 60), leadout);
    endtask

    // a disc: mostly a short run of rising track times, sometimes an empty
    // disc and sometimes one that goes past the track limit
    task automatic random_disc();
        int unsigned kind;
        int unsigned n_tracks;
        int unsigned step_max;
        int unsigned t;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            n_tracks = $urandom_range(MAX_TRACKS - 4, MAX_TRACKS + 11);
            step_max = 60;
        end else if (kind == 1) begin
            n_tracks = 0;
            step_max = 400;
        end else begin
            n_tracks = $urandom_range(1, 20);
            step_max = 400;
        end
        t = $urandom_range(0, 600);
        for (int unsigned k = 0; k < n_tracks; k++) begin
            put_time(t, 1'b0);
            t = (t + $urandom_range(1, step_max)) % (LAST_SEC + 1);
        end
        put_time(t, 1'b1);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty discs: lead-out alone, low, high and out of range
        put_word(cdid_pkg::MIN_W'(0),   cdid_pkg::SEC_W'(0),  1'b1);
        put_word(cdid_pkg::MIN_W'(127), cdid_pkg::SEC_W'(63), 1'b1);
        put_word(cdid_pkg::MIN_W'(100), cdid_pkg::SEC_W'(60), 1'b1);
        // single track at zero, lead-out at the top of the fields
        put_word(cdid_pkg::MIN_W'(0),   cdid_pkg::SEC_W'(0),  1'b0);
        put_word(cdid_pkg::MIN_W'(127), cdid_pkg::SEC_W'(63), 1'b1);
        // lead-out time below the first track's, so the span wraps
        put_word(cdid_pkg::MIN_W'(127), cdid_pkg::SEC_W'(63), 1'b0);
        put_word(cdid_pkg::MIN_W'(0),   cdid_pkg::SEC_W'(0),  1'b1);
        // four digit times, out of range fields and a short normal disc
        put_word(cdid_pkg::MIN_W'(99),  cdid_pkg::SEC_W'(59), 1'b0);
        put_word(cdid_pkg::MIN_W'(2),   cdid_pkg::SEC_W'(0),  1'b0);
        put_word(cdid_pkg::MIN_W'(100), cdid_pkg::SEC_W'(63), 1'b0);
        put_word(cdid_pkg::MIN_W'(3),   cdid_pkg::SEC_W'(30), 1'b1);
        put_word(cdid_pkg::MIN_W'(0),   cdid_pkg::SEC_W'(2),  1'b0);
        put_word(cdid_pkg::MIN_W'(1),   cdid_pkg::SEC_W'(35), 1'b0);
        put_word(cdid_pkg::MIN_W'(10),  cdid_pkg::SEC_W'(0),  1'b0);
        put_word(cdid_pkg::MIN_W'(60),  cdid_pkg::SEC_W'(0),  1'b1);

        while (n_sent < N_WORDS)
            random_disc();
        start <= 1'b0;

        // drain: every id must come out, then give the block time to misbehave
        while (board.pending_ids.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
